@@ src/ata_pkg.sv @@
`default_nettype none

package ata_pkg;

  // Field widths of the sample and result words.
  localparam int ACCEL_W = 12;
  localparam int ANGLE_W = 15;

  // CORDIC datapath: axes are scaled up by GUARD_BITS before the passes.
  localparam int GUARD_BITS = 20;
  localparam int DATA_W     = 40;

  // Angle accumulator in Q30 radians.
  localparam int ANGLE_Q        = 30;
  localparam int Z_W            = 32;
  localparam int ATAN_TABLE_LEN = 24;

  localparam int DEF_CORDIC_STEPS    = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 13;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 32'sd1686629713;

  localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_TABLE_LEN] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128
  };

  typedef enum logic [2:0] {
    MODE_CORDIC,
    MODE_ZERO,
    MODE_UNDEF,
    MODE_POS_HALF,
    MODE_NEG_HALF
  } ata_mode_t;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic                      operation;
  } ata_sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] tilt_angle;
    logic                      undefined_angle;
  } ata_result_t;

  // One CORDIC vector pair.
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } ata_vec_t;

  // Control that rides along with each word through the chain.
  typedef struct packed {
    ata_mode_t mode;
    logic      num_neg;
  } ata_side_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
    if (idx < ATAN_TABLE_LEN) begin
      return ATAN_Q30[idx];
    end
    return '0;
  endfunction

  // One vectoring rotation: drive y toward zero, shifts round toward minus infinity.
  function automatic ata_vec_t vec_step(input ata_vec_t v, input int sh);
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    ata_vec_t                 r;
    dx = $signed(v.y) >>> sh;
    dy = $signed(v.x) >>> sh;
    if (!v.y[DATA_W-1]) begin
      r.x = $signed(v.x) + dx;
      r.y = $signed(v.y) - dy;
    end else begin
      r.x = $signed(v.x) - dx;
      r.y = $signed(v.y) + dy;
    end
    return r;
  endfunction

  // Round a Q30 angle to frac_bits fraction bits, half up.
  function automatic logic signed [Z_W-1:0] round_q30(input logic signed [Z_W-1:0] z,
                                                      input int frac_bits);
    logic signed [Z_W-1:0] half;
    logic signed [Z_W-1:0] sum;
    half = Z_W'(1) <<< (ANGLE_Q - frac_bits - 1);
    sum  = z + half;
    return sum >>> (ANGLE_Q - frac_bits);
  endfunction

endpackage

`default_nettype wire

@@ src/ata_mag_cell.sv @@
`default_nettype none

// One rotation step of the first pass, on two lanes at once: the magnitude
// pair and the numerator scaled by the same gain.
module ata_mag_cell import ata_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      prev_valid,
  input  wire ata_side_t prev_side,
  input  wire ata_vec_t  prev_mag,
  input  wire ata_vec_t  prev_num,
  output logic           valid,
  output ata_side_t      side,
  output ata_vec_t       mag,
  output ata_vec_t       num
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side <= prev_side;
      mag  <= vec_step(prev_mag, STEP);
      num  <= vec_step(prev_num, STEP);
    end
  end

endmodule

`default_nettype wire

@@ src/ata_angle_cell.sv @@
`default_nettype none

// One rotation step of the arctangent pass, with its angle accumulator.
module ata_angle_cell import ata_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  prev_valid,
  input  wire ata_side_t             prev_side,
  input  wire ata_vec_t              prev_vec,
  input  wire logic signed [Z_W-1:0] prev_z,
  output logic                       valid,
  output ata_side_t                  side,
  output ata_vec_t                   vec,
  output logic signed [Z_W-1:0]      z
);

  localparam logic signed [Z_W-1:0] ATAN_STEP = atan_entry(STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side <= prev_side;
      vec  <= vec_step(prev_vec, STEP);
      z    <= prev_vec.y[DATA_W-1] ? prev_z - ATAN_STEP : prev_z + ATAN_STEP;
    end
  end

endmodule

`default_nettype wire

@@ src/accel_tilt_angle.sv @@
// Tilt angle (pitch or roll) of one accelerometer sample, fully pipelined.
// Throughput: one word per cycle; every rotation step is its own cell in the row.
// The whole row advances together and holds only while a finished result is stalled.
// Reset (rst, synchronous, active high) clears all valid flags; data is not cleared.
`default_nettype none

module accel_tilt_angle import ata_pkg::*; #(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_stall,
  input  wire ata_sample_t sample,
  output logic             result_valid,
  input  wire logic        result_stall,
  output ata_result_t      result
);

  // Rounded +/- pi/2 for the case of a zero denominator.
  localparam logic signed [Z_W-1:0] POS_HALF_PI = round_q30(HALF_PI_Q30, ANGLE_FRAC_BITS);
  localparam logic signed [Z_W-1:0] NEG_HALF_PI = round_q30(-HALF_PI_Q30, ANGLE_FRAC_BITS);

  localparam int PAD_W = DATA_W - ACCEL_W - GUARD_BITS;

  // The row moves as one unless the result register is full and stalled.
  logic en;
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  // Front end: pick numerator and denominator axes, take magnitudes and classify.
  logic signed [ACCEL_W-1:0] num_raw;
  logic signed [ACCEL_W-1:0] den_raw;
  logic [ACCEL_W-1:0]        num_abs;
  logic [ACCEL_W-1:0]        den_abs;
  logic [ACCEL_W-1:0]        z_abs;
  logic                      num_zero;
  logic                      den_zero;
  ata_side_t                 prep_side;
  ata_vec_t                  prep_mag;
  ata_vec_t                  prep_num;

  always_comb begin
    num_raw  = sample.operation ? sample.accel_y : sample.accel_x;
    den_raw  = sample.operation ? sample.accel_x : sample.accel_y;
    num_abs  = num_raw[ACCEL_W-1] ? ACCEL_W'(-num_raw) : num_raw;
    den_abs  = den_raw[ACCEL_W-1] ? ACCEL_W'(-den_raw) : den_raw;
    z_abs    = sample.accel_z[ACCEL_W-1] ? ACCEL_W'(-sample.accel_z) : sample.accel_z;
    num_zero = (num_raw == '0);
    den_zero = (den_abs == '0) && (z_abs == '0);

    prep_side.num_neg = num_raw[ACCEL_W-1];
    priority if (num_zero && den_zero) begin
      prep_side.mode = MODE_UNDEF;
    end else if (den_zero) begin
      prep_side.mode = num_raw[ACCEL_W-1] ? MODE_NEG_HALF : MODE_POS_HALF;
    end else if (num_zero) begin
      prep_side.mode = MODE_ZERO;
    end else begin
      prep_side.mode = MODE_CORDIC;
    end

    prep_mag.x = {{PAD_W{1'b0}}, den_abs, {GUARD_BITS{1'b0}}};
    prep_mag.y = {{PAD_W{1'b0}}, z_abs, {GUARD_BITS{1'b0}}};
    prep_num.x = {{PAD_W{1'b0}}, num_abs, {GUARD_BITS{1'b0}}};
    prep_num.y = '0;
  end

  // First pass: the magnitude of the denominator axes and the gain-matched
  // numerator, side by side in one row of cells. Entry 0 is the input register.
  logic      a_valid [CORDIC_STEPS+1];
  ata_side_t a_side  [CORDIC_STEPS+1];
  ata_vec_t  a_mag   [CORDIC_STEPS+1];
  ata_vec_t  a_num   [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid[0] <= 1'b0;
    end else if (en) begin
      a_valid[0] <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side[0] <= prep_side;
      a_mag[0]  <= prep_mag;
      a_num[0]  <= prep_num;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_mag
    ata_mag_cell #(
      .STEP(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .prev_valid(a_valid[i]),
      .prev_side (a_side[i]),
      .prev_mag  (a_mag[i]),
      .prev_num  (a_num[i]),
      .valid     (a_valid[i+1]),
      .side      (a_side[i+1]),
      .mag       (a_mag[i+1]),
      .num       (a_num[i+1])
    );
  end

  // Second pass: atan2(numerator, magnitude). Entry 0 is the join register,
  // which restores the numerator's sign.
  logic                  b_valid [CORDIC_STEPS+1];
  ata_side_t             b_side  [CORDIC_STEPS+1];
  ata_vec_t              b_vec   [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] b_z     [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid[0] <= 1'b0;
    end else if (en) begin
      b_valid[0] <= a_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side[0]  <= a_side[CORDIC_STEPS];
      b_vec[0].x <= a_mag[CORDIC_STEPS].x;
      b_vec[0].y <= a_side[CORDIC_STEPS].num_neg ? -a_num[CORDIC_STEPS].x
                                                 : a_num[CORDIC_STEPS].x;
      b_z[0]     <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_angle
    ata_angle_cell #(
      .STEP(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .prev_valid(b_valid[i]),
      .prev_side (b_side[i]),
      .prev_vec  (b_vec[i]),
      .prev_z    (b_z[i]),
      .valid     (b_valid[i+1]),
      .side      (b_side[i+1]),
      .vec       (b_vec[i+1]),
      .z         (b_z[i+1])
    );
  end

  // Back end: round the Q30 angle and apply the special cases.
  logic signed [Z_W-1:0] angle_rounded;
  logic signed [Z_W-1:0] angle_sel;
  logic                  undef_sel;

  always_comb begin
    angle_rounded = round_q30(b_z[CORDIC_STEPS], ANGLE_FRAC_BITS);
    undef_sel     = 1'b0;
    unique case (b_side[CORDIC_STEPS].mode)
      MODE_CORDIC:   angle_sel = angle_rounded;
      MODE_POS_HALF: angle_sel = POS_HALF_PI;
      MODE_NEG_HALF: angle_sel = NEG_HALF_PI;
      MODE_UNDEF: begin
        angle_sel = '0;
        undef_sel = 1'b1;
      end
      default:       angle_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= b_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.tilt_angle      <= angle_sel[ANGLE_W-1:0];
      result.undefined_angle <= undef_sel;
    end
  end

  // An undefined angle always comes out as zero.
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.undefined_angle |-> result.tilt_angle == '0)
    else $error("undefined angle word carries a nonzero angle");

  // The input register follows the sample channel whenever the row moved.
  a_front_follows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(en) |-> a_valid[0] == $past(sample_valid))
    else $error("input register valid does not follow an accepted word");

  // All-zero classification only ever comes with all-zero lanes.
  a_undef_lanes: assert property (@(posedge clk) disable iff (rst)
    a_valid[0] && a_side[0].mode == MODE_UNDEF |->
      a_mag[0].x == '0 && a_mag[0].y == '0 && a_num[0].x == '0)
    else $error("undefined mode with a nonzero axis");

  // The magnitude and scaled numerator leave the first pass non-negative.
  a_mag_positive: assert property (@(posedge clk) disable iff (rst)
    a_valid[CORDIC_STEPS] |->
      !a_mag[CORDIC_STEPS].x[DATA_W-1] && !a_num[CORDIC_STEPS].x[DATA_W-1])
    else $error("first pass magnitude went negative");

endmodule

`default_nettype wire
